// ===== rtl/lrc_pkg.sv =====
// Shared types and constants of the line and rectangle crossing block.
// Used by every module under rtl; depends on nothing.
package lrc_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int TOL_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_X_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOL = 3'd4;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_VERT = 2'd1;
  localparam logic [1:0] MODE_HORZ = 2'd2;
  localparam logic [1:0] MODE_GEN = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
  } seg_t;

  typedef struct packed {
    logic crossing_valid;
    logic signed [COORD_W-1:0] pos_from;
    logic signed [COORD_W-1:0] pos_till;
  } res_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_low;
    logic signed [COORD_W-1:0] x_high;
    logic signed [COORD_W-1:0] y_low;
    logic signed [COORD_W-1:0] y_high;
    logic [TOL_W-1:0] tol;
  } rect_t;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] ulx;
    logic signed [DIFF_W-1:0] uhx;
    logic signed [DIFF_W-1:0] vly;
    logic signed [DIFF_W-1:0] vhy;
  } setup_t;

  typedef struct packed {
    logic ok;
    logic signed [DIFF_W-1:0] num0;
    logic signed [DIFF_W-1:0] den0;
    logic signed [DIFF_W-1:0] num1;
    logic signed [DIFF_W-1:0] den1;
  } op_t;

  typedef struct packed {
    logic ok;
    logic signed [COORD_W-1:0] p0;
    logic signed [COORD_W-1:0] p1;
  } pos_t;

endpackage

// ===== rtl/lrc_setup.sv =====
// First pipeline stage: differences to the edges, tolerance tests and case selection.
// Depends on lrc_pkg.
module lrc_setup (
  input  logic clk,
  input  logic rst,
  input  lrc_pkg::rect_t rect,
  input  logic src_valid,
  output logic src_stall,
  input  lrc_pkg::seg_t src_data,
  output logic dst_valid,
  input  logic dst_stall,
  output lrc_pkg::setup_t dst_data
);
  localparam int DW = lrc_pkg::DIFF_W;
  localparam int W = lrc_pkg::COORD_W;

  logic valid;
  lrc_pkg::setup_t data_next;
  logic signed [DW-1:0] ax, ay, bx, by;
  logic [DW-1:0] adx, ady;
  logic near_x, near_y, empty, x_in, y_in;

  assign src_stall = valid && dst_stall;
  assign dst_valid = valid;

  always_comb begin
    ax = DW'(src_data.a_x);
    ay = DW'(src_data.a_y);
    bx = DW'(src_data.b_x);
    by = DW'(src_data.b_y);
    data_next.dx = bx - ax;
    data_next.dy = by - ay;
    data_next.ulx = DW'(rect.x_low) - ax;
    data_next.uhx = DW'(rect.x_high) - ax;
    data_next.vly = DW'(rect.y_low) - ay;
    data_next.vhy = DW'(rect.y_high) - ay;
    adx = data_next.dx[DW-1] ? -data_next.dx : data_next.dx;
    ady = data_next.dy[DW-1] ? -data_next.dy : data_next.dy;
    near_x = adx[W-1:0] <= W'(rect.tol);
    near_y = ady[W-1:0] <= W'(rect.tol);
    empty = (rect.x_low > rect.x_high) || (rect.y_low > rect.y_high);
    x_in = (rect.x_low <= src_data.a_x) && (src_data.a_x <= rect.x_high);
    y_in = (rect.y_low <= src_data.a_y) && (src_data.a_y <= rect.y_high);
    if (empty || (near_x && near_y)) begin
      data_next.mode = lrc_pkg::MODE_NONE;
    end else if (near_x) begin
      data_next.mode = x_in ? lrc_pkg::MODE_VERT : lrc_pkg::MODE_NONE;
    end else if (near_y) begin
      data_next.mode = y_in ? lrc_pkg::MODE_HORZ : lrc_pkg::MODE_NONE;
    end else begin
      data_next.mode = lrc_pkg::MODE_GEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!src_stall) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall) begin
      dst_data <= data_next;
    end
  end
endmodule

// ===== rtl/lrc_hit.sv =====
// Edge hit stages: four cross products, exact bound tests and choice of the two crossings.
// Depends on lrc_pkg.
module lrc_hit (
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_stall,
  input  lrc_pkg::setup_t src_data,
  output logic dst_valid,
  input  logic dst_stall,
  output lrc_pkg::op_t dst_data
);
  localparam int DW = lrc_pkg::DIFF_W;
  localparam int PW = lrc_pkg::PROD_W;

  logic va, vb, hold_a, hold_b;
  lrc_pkg::setup_t s;
  logic signed [PW-1:0] p1, p2, p3, p4;
  logic [3:0] hit;
  logic [1:0] idx0, idx1;
  logic signed [DW-1:0] num [0:3];
  logic signed [DW-1:0] den [0:3];
  lrc_pkg::op_t op_next;

  assign hold_b = vb && dst_stall;
  assign hold_a = va && hold_b;
  assign src_stall = hold_a;
  assign dst_valid = vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (!hold_a) va <= src_valid;
      if (!hold_b) vb <= va;
    end
  end

  // The product of dy and the distance to a vertical edge doubles as the
  // bound term of the horizontal edge tests, so four products cover all.
  always_ff @(posedge clk) begin
    if (!hold_a) begin
      s <= src_data;
      p1 <= src_data.dy * src_data.ulx;
      p2 <= src_data.dy * src_data.uhx;
      p3 <= src_data.dx * src_data.vly;
      p4 <= src_data.dx * src_data.vhy;
    end
  end

  always_comb begin
    hit[0] = s.dx[DW-1] ? (p3 >= p1 && p1 >= p4) : (p3 <= p1 && p1 <= p4);
    hit[1] = s.dx[DW-1] ? (p3 >= p2 && p2 >= p4) : (p3 <= p2 && p2 <= p4);
    hit[2] = s.dy[DW-1] ? (p1 >= p3 && p3 >= p2) : (p1 <= p3 && p3 <= p2);
    hit[3] = s.dy[DW-1] ? (p1 >= p4 && p4 >= p2) : (p1 <= p4 && p4 <= p2);
    num[0] = s.ulx;
    num[1] = s.uhx;
    num[2] = s.vly;
    num[3] = s.vhy;
    den[0] = s.dx;
    den[1] = s.dx;
    den[2] = s.dy;
    den[3] = s.dy;
    idx0 = 2'd0;
    idx1 = 2'd1;
    op_next.ok = 1'b0;
    case (s.mode)
      lrc_pkg::MODE_VERT: begin
        idx0 = 2'd2;
        idx1 = 2'd3;
        op_next.ok = 1'b1;
      end
      lrc_pkg::MODE_HORZ: begin
        op_next.ok = 1'b1;
      end
      lrc_pkg::MODE_GEN: begin
        // Left, right, bottom, top in order; the first two hits count.
        if (hit[0]) begin
          idx0 = 2'd0;
          idx1 = hit[1] ? 2'd1 : (hit[2] ? 2'd2 : 2'd3);
        end else if (hit[1]) begin
          idx0 = 2'd1;
          idx1 = hit[2] ? 2'd2 : 2'd3;
        end else begin
          idx0 = 2'd2;
          idx1 = 2'd3;
        end
        op_next.ok = $countones(hit) >= 2;
      end
      default: begin
        op_next.ok = 1'b0;
      end
    endcase
    op_next.num0 = num[idx0];
    op_next.den0 = den[idx0];
    op_next.num1 = num[idx1];
    op_next.den1 = den[idx1];
  end

  always_ff @(posedge clk) begin
    if (!hold_b) begin
      dst_data <= op_next;
    end
  end
endmodule

// ===== rtl/lrc_div.sv =====
// Two-lane pipelined restoring divider: one quotient bit per stage, then saturation and sign.
// Depends on lrc_pkg.
module lrc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_stall,
  input  lrc_pkg::op_t src_data,
  output logic dst_valid,
  input  logic dst_stall,
  output lrc_pkg::pos_t dst_data
);
  localparam int W = lrc_pkg::COORD_W;
  localparam int DW = lrc_pkg::DIFF_W;
  localparam int RW = 2 * W + FRAC_BITS;
  localparam int NSTEP = W + 1;
  localparam int NS = NSTEP + 2;
  localparam logic [W:0] MAXPOS = {2'b00, {(W-1){1'b1}}};

  logic v [0:NS-1];
  logic hold [0:NS-1];
  logic [RW-1:0] rem [0:NSTEP][0:1];
  logic [W-1:0] dv [0:NSTEP][0:1];
  logic [W:0] quo [0:NSTEP][0:1];
  logic ng [0:NSTEP][0:1];
  logic okb [0:NSTEP];

  logic signed [DW-1:0] pn [0:1];
  logic signed [DW-1:0] pd [0:1];
  logic [DW-1:0] an [0:1];
  logic [DW-1:0] ad [0:1];
  logic [W:0] lim [0:1];
  logic [W:0] mag [0:1];
  logic [W:0] sv [0:1];

  assign src_stall = hold[0];
  assign dst_valid = v[NS-1];
  assign hold[NS-1] = v[NS-1] && dst_stall;

  genvar k;
  generate
    for (k = 0; k < NS - 1; k++) begin : g_hold
      assign hold[k] = v[k] && hold[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (!hold[0]) begin
      v[0] <= src_valid;
    end
  end

  always_comb begin
    pn[0] = src_data.num0;
    pd[0] = src_data.den0;
    pn[1] = src_data.num1;
    pd[1] = src_data.den1;
    for (int l = 0; l < 2; l++) begin
      an[l] = pn[l][DW-1] ? -pn[l] : pn[l];
      ad[l] = pd[l][DW-1] ? -pd[l] : pd[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      okb[0] <= src_data.ok;
      for (int l = 0; l < 2; l++) begin
        rem[0][l] <= RW'(an[l][W-1:0]) << FRAC_BITS;
        dv[0][l] <= ad[l][W-1:0];
        quo[0][l] <= '0;
        ng[0][l] <= pn[l][DW-1] ^ pd[l][DW-1];
      end
    end
  end

  // Stage k settles quotient bit W+1-k. The top bit only flags a quotient
  // too large for the output range, which then saturates.
  generate
    for (k = 1; k <= NSTEP; k++) begin : g_step
      localparam int B = W + 1 - k;
      logic [RW-1:0] dsh [0:1];
      logic ge [0:1];

      always_comb begin
        for (int l = 0; l < 2; l++) begin
          dsh[l] = RW'(dv[k-1][l]) << B;
          ge[l] = rem[k-1][l] >= dsh[l];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (!hold[k]) begin
          v[k] <= v[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (!hold[k]) begin
          okb[k] <= okb[k-1];
          for (int l = 0; l < 2; l++) begin
            rem[k][l] <= ge[l] ? rem[k-1][l] - dsh[l] : rem[k-1][l];
            dv[k][l] <= dv[k-1][l];
            quo[k][l] <= quo[k-1][l] | ((W+1)'(ge[l]) << B);
            ng[k][l] <= ng[k-1][l];
          end
        end
      end
    end
  endgenerate

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lim[l] = MAXPOS + (W+1)'(ng[NSTEP][l]);
      mag[l] = (quo[NSTEP][l] > lim[l]) ? lim[l] : quo[NSTEP][l];
      sv[l] = ng[NSTEP][l] ? -mag[l] : mag[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[NS-1] <= 1'b0;
    end else if (!hold[NS-1]) begin
      v[NS-1] <= v[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!hold[NS-1]) begin
      dst_data.ok <= okb[NSTEP];
      dst_data.p0 <= sv[0][W-1:0];
      dst_data.p1 <= sv[1][W-1:0];
    end
  end
endmodule

// ===== rtl/line_rectangle_crossing.sv =====
// Line through A and B against a rectangle held in registers: reports the two
// parametric crossing positions, sorted, as signed fixed point. One segment
// word is taken every clock while seg_stall is low; the path is a fixed pipeline
// of COORD_W + 7 stages (39 at 32-bit coordinates), set by the divider that
// settles one quotient bit per stage. Each stage holds only when the one after
// it is full and held, so bubbles close up and the block keeps taking words
// while a result waits at the output. Configuration writes are always ready.
// Depends on lrc_pkg, lrc_setup, lrc_hit and lrc_div.
module line_rectangle_crossing #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [lrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrc_pkg::COORD_W-1:0] cfg_data,
  input  logic seg_valid,
  output logic seg_stall,
  input  lrc_pkg::seg_t seg_data,
  output logic res_valid,
  input  logic res_stall,
  output lrc_pkg::res_t res_data
);
  lrc_pkg::rect_t rect;
  logic s_valid, s_stall, h_valid, h_stall, d_valid, d_stall, hold;
  lrc_pkg::setup_t s_data;
  lrc_pkg::op_t h_data;
  lrc_pkg::pos_t d_data;
  lrc_pkg::res_t res_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect.x_low <= '0;
      rect.x_high <= '0;
      rect.y_low <= '0;
      rect.y_high <= '0;
      rect.tol <= lrc_pkg::TOL_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        lrc_pkg::REG_X_LOW: rect.x_low <= cfg_data;
        lrc_pkg::REG_X_HIGH: rect.x_high <= cfg_data;
        lrc_pkg::REG_Y_LOW: rect.y_low <= cfg_data;
        lrc_pkg::REG_Y_HIGH: rect.y_high <= cfg_data;
        lrc_pkg::REG_TOL: rect.tol <= cfg_data[lrc_pkg::TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lrc_setup u_setup (
    .clk(clk), .rst(rst), .rect(rect),
    .src_valid(seg_valid), .src_stall(seg_stall), .src_data(seg_data),
    .dst_valid(s_valid), .dst_stall(s_stall), .dst_data(s_data)
  );

  lrc_hit u_hit (
    .clk(clk), .rst(rst),
    .src_valid(s_valid), .src_stall(s_stall), .src_data(s_data),
    .dst_valid(h_valid), .dst_stall(h_stall), .dst_data(h_data)
  );

  lrc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst),
    .src_valid(h_valid), .src_stall(h_stall), .src_data(h_data),
    .dst_valid(d_valid), .dst_stall(d_stall), .dst_data(d_data)
  );

  assign hold = res_valid && res_stall;
  assign d_stall = hold;

  always_comb begin
    res_next.crossing_valid = d_data.ok;
    res_next.pos_from = '0;
    res_next.pos_till = '0;
    if (d_data.ok) begin
      if (d_data.p0 > d_data.p1) begin
        res_next.pos_from = d_data.p1;
        res_next.pos_till = d_data.p0;
      end else begin
        res_next.pos_from = d_data.p0;
        res_next.pos_till = d_data.p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!hold) begin
      res_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      res_data <= res_next;
    end
  end
endmodule

// ===== sim/lrc_checker.sv =====
// Checker for the line and rectangle crossing block: watches the config,
// segment and result channels, predicts each result and compares it.
// Depends on lrc_pkg.
module lrc_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [lrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrc_pkg::COORD_W-1:0] cfg_data,
  input  logic seg_valid,
  input  logic seg_stall,
  input  lrc_pkg::seg_t seg_data,
  input  logic res_valid,
  input  logic res_stall,
  input  lrc_pkg::res_t res_data,
  output int fail_count,
  output int pending,
  output int seen_valid,
  output int seen_invalid
);
  localparam int COORD_W = lrc_pkg::COORD_W;
  localparam int DIFF_W = lrc_pkg::DIFF_W;
  localparam int TOL_W = lrc_pkg::TOL_W;
  localparam int FRAC_BITS_TB = 16;

  logic signed [COORD_W-1:0] x_low, x_high, y_low, y_high;
  logic [TOL_W-1:0] tol;
  lrc_pkg::res_t crossing_q[$];

  // Exact num/den in fixed point, truncated toward zero, then saturated.
  function automatic logic signed [COORD_W-1:0] frac_pos(
      logic signed [DIFF_W-1:0] num, logic signed [DIFF_W-1:0] den);
    logic signed [127:0] n, d, q, lim;
    logic neg;
    if (den == 0) return '0;
    n = num;
    d = den;
    neg = (n < 0) != (d < 0) && n != 0;
    if (n < 0) n = -n;
    if (d < 0) d = -d;
    q = (n <<< FRAC_BITS_TB) / d;
    lim = neg ? (128'sd1 <<< (COORD_W - 1)) : (128'sd1 <<< (COORD_W - 1)) - 1;
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[COORD_W-1:0];
  endfunction

  // Is a0 + nd*nu/den inside [lo, hi]; exact by cross-multiplication.
  function automatic logic lies_within(logic signed [COORD_W-1:0] lo,
      logic signed [COORD_W-1:0] hi, logic signed [COORD_W-1:0] a0,
      logic signed [DIFF_W-1:0] nd, logic signed [DIFF_W-1:0] nu,
      logic signed [DIFF_W-1:0] den);
    logic signed [127:0] p, l, h;
    p = 128'(nd) * 128'(nu);
    l = (128'(lo) - 128'(a0)) * 128'(den);
    h = (128'(hi) - 128'(a0)) * 128'(den);
    if (den < 0) return l >= p && p >= h;
    return l <= p && p <= h;
  endfunction

  function automatic lrc_pkg::res_t predict_crossing(lrc_pkg::seg_t s);
    lrc_pkg::res_t r;
    logic signed [DIFF_W-1:0] dx, dy, u, t;
    logic signed [COORD_W-1:0] hit[2];
    logic vert, horz, ok;
    int n;
    dx = DIFF_W'(s.b_x) - DIFF_W'(s.a_x);
    dy = DIFF_W'(s.b_y) - DIFF_W'(s.a_y);
    vert = (dx < 0 ? -dx : dx) <= $signed({1'b0, tol});
    horz = (dy < 0 ? -dy : dy) <= $signed({1'b0, tol});
    ok = 0;
    n = 0;
    hit[0] = '0;
    hit[1] = '0;
    if (x_low > x_high || y_low > y_high || (vert && horz)) begin
      ok = 0;
    end else if (vert) begin
      if (x_low <= s.a_x && s.a_x <= x_high) begin
        hit[0] = frac_pos(DIFF_W'(y_low) - DIFF_W'(s.a_y), dy);
        hit[1] = frac_pos(DIFF_W'(y_high) - DIFF_W'(s.a_y), dy);
        ok = 1;
      end
    end else if (horz) begin
      if (y_low <= s.a_y && s.a_y <= y_high) begin
        hit[0] = frac_pos(DIFF_W'(x_low) - DIFF_W'(s.a_x), dx);
        hit[1] = frac_pos(DIFF_W'(x_high) - DIFF_W'(s.a_x), dx);
        ok = 1;
      end
    end else begin
      u = DIFF_W'(x_low) - DIFF_W'(s.a_x);
      if (lies_within(y_low, y_high, s.a_y, dy, u, dx)) begin
        hit[n] = frac_pos(u, dx);
        n = n + 1;
      end
      u = DIFF_W'(x_high) - DIFF_W'(s.a_x);
      if (lies_within(y_low, y_high, s.a_y, dy, u, dx)) begin
        hit[n] = frac_pos(u, dx);
        n = n + 1;
      end
      u = DIFF_W'(y_low) - DIFF_W'(s.a_y);
      if (n < 2 && lies_within(x_low, x_high, s.a_x, dx, u, dy)) begin
        hit[n] = frac_pos(u, dy);
        n = n + 1;
      end
      u = DIFF_W'(y_high) - DIFF_W'(s.a_y);
      if (n < 2 && lies_within(x_low, x_high, s.a_x, dx, u, dy)) begin
        hit[n] = frac_pos(u, dy);
        n = n + 1;
      end
      ok = (n == 2);
    end
    r = '0;
    if (ok) begin
      r.crossing_valid = 1'b1;
      if (hit[0] > hit[1]) begin
        t = hit[0];
        hit[0] = hit[1];
        hit[1] = t[COORD_W-1:0];
      end
      r.pos_from = hit[0];
      r.pos_till = hit[1];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lrc_pkg::res_t want;
    if (rst) begin
      x_low <= '0;
      x_high <= '0;
      y_low <= '0;
      y_high <= '0;
      tol <= 16'd1;
      fail_count <= 0;
      seen_valid <= 0;
      seen_invalid <= 0;
      pending <= 0;
      crossing_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lrc_pkg::REG_X_LOW: x_low <= cfg_data;
          lrc_pkg::REG_X_HIGH: x_high <= cfg_data;
          lrc_pkg::REG_Y_LOW: y_low <= cfg_data;
          lrc_pkg::REG_Y_HIGH: y_high <= cfg_data;
          lrc_pkg::REG_TOL: tol <= cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end
      if (seg_valid && !seg_stall) crossing_q.push_back(predict_crossing(seg_data));
      if (res_valid && !res_stall) begin
        if (crossing_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", res_data);
          fail_count <= fail_count + 1;
        end else begin
          want = crossing_q.pop_front();
          if (want.crossing_valid) seen_valid <= seen_valid + 1;
          else seen_invalid <= seen_invalid + 1;
          if (res_data !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected v=%0d from=%0d till=%0d, got v=%0d from=%0d till=%0d",
                       want.crossing_valid, want.pos_from, want.pos_till,
                       res_data.crossing_valid, res_data.pos_from, res_data.pos_till);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= crossing_q.size();
    end
  end
endmodule

// ===== sim/tb_top.sv =====
// Testbench top for line_rectangle_crossing: drives configuration and
// segment words, stalls results at random and gives the verdict.
// Depends on lrc_pkg, the block and lrc_checker.
module tb_top;
  localparam int WATCH_LIMIT = 20000;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [lrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lrc_pkg::COORD_W-1:0] cfg_data = '0;
  logic seg_valid = 0, seg_stall;
  lrc_pkg::seg_t seg_data = '0;
  logic res_valid, res_stall = 0;
  lrc_pkg::res_t res_data;
  int fail_count, pending, seen_valid, seen_invalid;
  int idle_pct = 25;
  int hold_off = 0;
  int quiet = 0;

  always #5 clk = ~clk;

  line_rectangle_crossing uut (.*);
  lrc_checker chk (.*);

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      res_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      res_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((seg_valid && !seg_stall) || (res_valid && !res_stall) || cfg_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [lrc_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(40, 0)) - 20) <<< 16
               | 32'($urandom_range(3));
    endcase
  endfunction

  task automatic write_reg(logic [lrc_pkg::CFG_IDX_W-1:0] idx,
                           logic [lrc_pkg::COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_rect(logic [31:0] xl, logic [31:0] xh, logic [31:0] yl,
                          logic [31:0] yh, logic [15:0] t);
    write_reg(lrc_pkg::REG_X_LOW, xl);
    write_reg(lrc_pkg::REG_X_HIGH, xh);
    write_reg(lrc_pkg::REG_Y_LOW, yl);
    write_reg(lrc_pkg::REG_Y_HIGH, yh);
    write_reg(lrc_pkg::REG_TOL, {16'd0, t});
  endtask

  task automatic send_seg(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                          logic [31:0] by);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      seg_valid <= 1'b0;
      @(posedge clk);
    end
    seg_valid <= 1'b1;
    seg_data <= '{ax, ay, bx, by};
    @(posedge clk);
    while (seg_stall) @(posedge clk);
  endtask

  task automatic drain();
    seg_valid <= 1'b0;
    @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_segs(int count);
    logic [31:0] ax, ay, bx, by;
    for (int i = 0; i < count; i++) begin
      ax = pick_coord();
      ay = pick_coord();
      bx = pick_coord();
      by = pick_coord();
      case ($urandom_range(5))
        0: bx = ax + $urandom_range(2);
        1: by = ay + $urandom_range(2);
        default: ;
      endcase
      send_seg(ax, ay, bx, by);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Rectangle [-4,4] x [-2,2] in Q16.16.
    set_rect(-32'sd262144, 32'sd262144, -32'sd131072, 32'sd131072, 16'd1);
    send_seg(-32'sd524288, 0, 32'sd524288, 0);
    send_seg(0, -32'sd524288, 0, 32'sd524288);
    send_seg(-32'sd524288, -32'sd262144, 32'sd524288, 32'sd262144);
    send_seg(-32'sd262144, -32'sd131072, 32'sd262144, 32'sd131072);
    send_seg(0, 0, 0, 0);
    send_seg(0, 0, 1, 1);
    send_seg(0, 32'sd524288, 32'sd65536, 32'sd524288);
    send_seg(32'sd524288, 0, 32'sd524288, 32'sd65536);
    send_seg(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_seg(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_seg(0, 0, 32'd1, 32'h7fff_ffff);
    send_seg(32'sd524288, 32'sd131072, 32'sd524289, 32'sd131072);
    send_seg(0, 0, 32'sd1, 32'sd2);
    drain();
    // Empty rectangle.
    set_rect(32'sd65536, -32'sd65536, 0, 32'sd65536, 16'd0);
    send_seg(-32'sd524288, 0, 32'sd524288, 32'sd3);
    drain();
    // Extreme rectangle and tolerance.
    set_rect(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'hffff);
    send_seg(0, 0, 32'hffff, 32'sd65536);
    send_seg(0, 0, 32'sd65536, 32'hffff);
    send_seg(32'h8000_0000, 0, 32'h7fff_ffff, 32'sd5);
    random_segs(200);
    drain();
    // Mid-size rectangle, no idling at all for a long stretch.
    set_rect(-32'sd655360, 32'sd393216, -32'sd524288, 32'sd720896, 16'd3);
    idle_pct = 0;
    random_segs(300);
    idle_pct = 25;
    // Receiver holds off while the sender keeps offering.
    hold_off = 400;
    random_segs(300);
    drain();
    set_rect(-32'sd1310720, 32'sd1310720, 0, 0, 16'd0);
    random_segs(300);
    drain();
    set_rect(32'sd3, 32'sd3, -32'sd1310720, 32'sd1310720, 16'd1);
    random_segs(300);
    drain();
    set_rect($urandom, $urandom, $urandom, $urandom, 16'($urandom));
    random_segs(350);
    drain();
    $display("Covered %0d crossings and %0d misses over seven rectangle settings.",
             seen_valid, seen_invalid);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
